>>> hw/rtl/pta_pkg.sv
// ----------------------------------------------------------------------------
// pta_pkg: shared types and constants of the page table allocator
// Sizes of the physical page space and the process table, result status
// codes, controller states and the command and status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package pta_pkg;

	// Physical pages, processes and entries per page table.
	localparam int PAGES     = 64;
	localparam int PROCESSES = 64;
	localparam int ENTRIES   = 64;

	localparam int PAGE_W  = $clog2(PAGES);
	localparam int PROC_W  = $clog2(PROCESSES);
	localparam int ENTRY_W = $clog2(ENTRIES);
	localparam int PT_AW   = PAGE_W + ENTRY_W;
	localparam int PT_DEPTH = PAGES * ENTRIES;

	// Field widths of the request and result ports.
	localparam int FIELD_W = 6;
	localparam int MAP_W   = 64;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OOM_TABLE = 2'd1,
		ST_OOM_DATA  = 2'd2
	} status_t;

	// Function codes of a request.
	localparam logic FUNC_ALLOC  = 1'b0;
	localparam logic FUNC_LOOKUP = 1'b1;

	// Controller states.
	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN_TAB,
		S_SCAN_DATA,
		S_LK_PTR,
		S_LK_ENT,
		S_LK_FIN,
		S_RESP
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    clr_step;    // clear one table entry and one pointer
		logic    load;        // latch the request, restart the scan
		logic    take_table;  // take the scanned page as the page table
		logic    take_data;   // take the scanned page as the next data page
		logic    scan_next;   // move the scan pointer to the next page
		logic    set_status;  // record an out-of-memory status
		status_t status_val;
		logic    lookup_fin;  // copy the looked up entry to the result
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clr_last;    // clearing pass is on its last entry
		logic req_lookup;  // request on the input ports is a lookup
		logic req_ok;      // request on the input ports names a valid process
		logic page_free;   // page under the scan pointer is free
		logic scan_last;   // scan pointer is on the last page
		logic count_zero;  // no data pages requested
		logic idx_last;    // next data page is the last one requested
	} stat_t;

endpackage

>>> hw/rtl/pta_ctrl.sv
// ----------------------------------------------------------------------------
// pta_ctrl: controller of the page table allocator
// Sequences the clearing pass after reset, the free page scan of an
// allocation, the table reads of a lookup and the one-cycle result strobe.
// ----------------------------------------------------------------------------
module pta_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  pta_pkg::stat_t  stat,
	output pta_pkg::cmd_t   cmd,
	output logic            busy,
	output logic            done
);

	pta_pkg::state_t state_q, state_next;

	// State register; the clearing pass runs first after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pta_pkg::S_CLEAR;
		end else begin
			state_q <= state_next;
		end
	end

	// Next state and commands.
	always_comb begin
		state_next     = state_q;
		cmd            = '0;
		cmd.status_val = pta_pkg::ST_OK;
		busy           = (state_q != pta_pkg::S_IDLE);
		done           = 1'b0;
		case (state_q)
			pta_pkg::S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_last) begin
					state_next = pta_pkg::S_IDLE;
				end
			end
			pta_pkg::S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					if (!stat.req_ok) begin
						state_next = pta_pkg::S_RESP;
					end else if (stat.req_lookup) begin
						state_next = pta_pkg::S_LK_PTR;
					end else begin
						state_next = pta_pkg::S_SCAN_TAB;
					end
				end
			end
			pta_pkg::S_SCAN_TAB: begin
				if (stat.page_free) begin
					cmd.take_table = 1'b1;
					if (stat.count_zero) begin
						state_next = pta_pkg::S_RESP;
					end else if (stat.scan_last) begin
						cmd.set_status = 1'b1;
						cmd.status_val = pta_pkg::ST_OOM_DATA;
						state_next     = pta_pkg::S_RESP;
					end else begin
						cmd.scan_next = 1'b1;
						state_next    = pta_pkg::S_SCAN_DATA;
					end
				end else if (stat.scan_last) begin
					cmd.set_status = 1'b1;
					cmd.status_val = pta_pkg::ST_OOM_TABLE;
					state_next     = pta_pkg::S_RESP;
				end else begin
					cmd.scan_next = 1'b1;
				end
			end
			pta_pkg::S_SCAN_DATA: begin
				if (stat.page_free) begin
					cmd.take_data = 1'b1;
				end
				if (stat.page_free && stat.idx_last) begin
					state_next = pta_pkg::S_RESP;
				end else if (stat.scan_last) begin
					cmd.set_status = 1'b1;
					cmd.status_val = pta_pkg::ST_OOM_DATA;
					state_next     = pta_pkg::S_RESP;
				end else begin
					cmd.scan_next = 1'b1;
				end
			end
			pta_pkg::S_LK_PTR: begin
				state_next = pta_pkg::S_LK_ENT;
			end
			pta_pkg::S_LK_ENT: begin
				state_next = pta_pkg::S_LK_FIN;
			end
			pta_pkg::S_LK_FIN: begin
				cmd.lookup_fin = 1'b1;
				state_next     = pta_pkg::S_RESP;
			end
			pta_pkg::S_RESP: begin
				done       = 1'b1;
				state_next = pta_pkg::S_IDLE;
			end
			default: begin
				state_next = pta_pkg::S_IDLE;
			end
		endcase
	end

endmodule

>>> hw/rtl/pta_datapath.sv
// ----------------------------------------------------------------------------
// pta_datapath: storage and scan logic of the page table allocator
// Holds the used-page map, the per-process table pointers, the page table
// store, the free page scan pointer and the result registers.
// ----------------------------------------------------------------------------
module pta_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pta_pkg::cmd_t                 cmd,
	output pta_pkg::stat_t                stat,
	input  logic                          func,
	input  logic [pta_pkg::FIELD_W-1:0]   process,
	input  logic [pta_pkg::FIELD_W-1:0]   data_pages,
	input  logic [pta_pkg::FIELD_W-1:0]   virtual_page,
	output logic [1:0]                    status,
	output logic [pta_pkg::FIELD_W-1:0]   page,
	output logic [pta_pkg::MAP_W-1:0]     free_map
);

	// Memories: table pointers per process and the page table store.
	logic [pta_pkg::PAGE_W-1:0] ptr_mem [pta_pkg::PROCESSES];
	logic [pta_pkg::PAGE_W-1:0] pt_mem  [pta_pkg::PT_DEPTH];

	logic [pta_pkg::PAGES-1:0]   used_q;
	logic [pta_pkg::PT_AW-1:0]   clr_cnt_q;
	logic [pta_pkg::PAGE_W-1:0]  scan_q;
	logic [pta_pkg::PAGE_W-1:0]  tab_q;
	logic [pta_pkg::ENTRY_W-1:0] idx_q;
	logic [pta_pkg::PROC_W-1:0]  proc_q;
	logic [pta_pkg::ENTRY_W-1:0] vpage_q;
	logic [pta_pkg::FIELD_W-1:0] count_q;
	logic [pta_pkg::PAGE_W-1:0]  ptr_rd_q;
	logic [pta_pkg::PAGE_W-1:0]  ent_rd_q;
	pta_pkg::status_t            status_q;
	logic [pta_pkg::PAGE_W-1:0]  page_q;

	logic [pta_pkg::FIELD_W:0]   idx_plus;

	// Status toward the controller.
	assign idx_plus = {1'b0, pta_pkg::FIELD_W'(idx_q)} + 1'b1;
	always_comb begin
		stat.clr_last   = (clr_cnt_q == pta_pkg::PT_AW'(pta_pkg::PT_DEPTH - 1));
		stat.req_lookup = (func == pta_pkg::FUNC_LOOKUP);
		stat.req_ok     = (int'(process) < pta_pkg::PROCESSES);
		stat.page_free  = !used_q[scan_q];
		stat.scan_last  = (scan_q == pta_pkg::PAGE_W'(pta_pkg::PAGES - 1));
		stat.count_zero = (count_q == '0);
		stat.idx_last   = (idx_plus == {1'b0, count_q});
	end

	// Clearing pass counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clr_step) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	// Used-page map; page 0 is reserved at reset and never handed out.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= pta_pkg::PAGES'(1);
		end else if (cmd.take_table || cmd.take_data) begin
			used_q[scan_q] <= 1'b1;
		end
	end

	// Request registers, scan pointer and data page index.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			proc_q  <= pta_pkg::PROC_W'(process);
			vpage_q <= pta_pkg::ENTRY_W'(virtual_page);
			count_q <= data_pages;
			scan_q  <= pta_pkg::PAGE_W'(1);
			idx_q   <= '0;
		end else begin
			if (cmd.scan_next) begin
				scan_q <= scan_q + 1'b1;
			end
			if (cmd.take_table) begin
				tab_q <= scan_q;
			end
			if (cmd.take_data) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// Result registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			status_q <= pta_pkg::ST_OK;
			page_q   <= '0;
		end else begin
			if (cmd.set_status) begin
				status_q <= cmd.status_val;
			end
			if (cmd.take_table) begin
				page_q <= scan_q;
			end else if (cmd.lookup_fin && (ptr_rd_q != '0)) begin
				page_q <= ent_rd_q;
			end
		end
	end

	// Table pointer memory: cleared by the pass, written when a table is taken.
	always_ff @(posedge clk) begin
		if (cmd.clr_step) begin
			ptr_mem[clr_cnt_q[pta_pkg::PROC_W-1:0]] <= '0;
		end else if (cmd.take_table) begin
			ptr_mem[proc_q] <= scan_q;
		end
		ptr_rd_q <= ptr_mem[proc_q];
	end

	// Page table store: entry e of the table in page t sits at {t, e}.
	always_ff @(posedge clk) begin
		if (cmd.clr_step) begin
			pt_mem[clr_cnt_q] <= '0;
		end else if (cmd.take_data) begin
			pt_mem[{tab_q, idx_q}] <= scan_q;
		end
		ent_rd_q <= pt_mem[{ptr_rd_q, vpage_q}];
	end

	// Result ports.
	assign status   = status_q;
	assign page     = pta_pkg::FIELD_W'(page_q);
	assign free_map = pta_pkg::MAP_W'(used_q);

endmodule

>>> hw/rtl/page_table_allocator.sv
// ----------------------------------------------------------------------------
// page_table_allocator: physical page allocator with per-process page tables
// Top level joining the controller and the datapath.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the page table store, one
// entry a cycle with busy high, then takes a request when start is high and
// busy is low. An allocation accepts the request, then scans the used-page
// map one page a cycle, at most 63 pages, with a pointer that only moves
// forward, and then gives the result strobe. A lookup gives its result after
// the two registered memory reads of table pointer and table entry. The
// result is on status, page and free_map for exactly the one cycle in which
// done is high; the receiver cannot stall it, and the next request is taken
// the cycle after.
// ----------------------------------------------------------------------------
module page_table_allocator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          func,
	input  logic [pta_pkg::FIELD_W-1:0]   process,
	input  logic [pta_pkg::FIELD_W-1:0]   data_pages,
	input  logic [pta_pkg::FIELD_W-1:0]   virtual_page,
	output logic                          done,
	output logic [1:0]                    status,
	output logic [pta_pkg::FIELD_W-1:0]   page,
	output logic [pta_pkg::MAP_W-1:0]     free_map
);

	pta_pkg::cmd_t  cmd;
	pta_pkg::stat_t stat;

	// Controller.
	pta_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// Datapath.
	pta_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.func         (func),
		.process      (process),
		.data_pages   (data_pages),
		.virtual_page (virtual_page),
		.status       (status),
		.page         (page),
		.free_map     (free_map)
	);

endmodule

>>> tb/page_table_allocator_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_table_allocator_checker: result prediction and comparison
// Watches the request and result ports of the page table allocator, keeps its
// own copy of the used-page map, the table pointers and the page table store,
// works out the reply to every accepted request and compares each result
// strobe with the oldest outstanding reply, field by field.
// ----------------------------------------------------------------------------
module page_table_allocator_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          busy,
	input  logic                          func,
	input  logic [pta_pkg::FIELD_W-1:0]   process,
	input  logic [pta_pkg::FIELD_W-1:0]   data_pages,
	input  logic [pta_pkg::FIELD_W-1:0]   virtual_page,
	input  logic                          done,
	input  logic [1:0]                    status,
	input  logic [pta_pkg::FIELD_W-1:0]   page,
	input  logic [pta_pkg::MAP_W-1:0]     free_map,
	output int                            failures,
	output int                            pending
);

	typedef struct {
		pta_pkg::status_t              status;
		logic [pta_pkg::PAGE_W-1:0]    page;
		logic [pta_pkg::MAP_W-1:0]     map;
	} page_reply_t;

	// Shadow state of the allocator.
	logic [pta_pkg::PAGES-1:0]  used_map;
	logic [pta_pkg::PAGE_W-1:0] table_of_process [pta_pkg::PROCESSES];
	logic [pta_pkg::PAGE_W-1:0] mapped_page [pta_pkg::PT_DEPTH];
	page_reply_t                replies_due [$];

	// First fit from page 1 up; page 0 means nothing was free.
	function automatic logic [pta_pkg::PAGE_W-1:0] claim_lowest_free();
		for (int p = 1; p < pta_pkg::PAGES; p++) begin
			if (!used_map[p]) begin
				used_map[p] = 1'b1;
				return p[pta_pkg::PAGE_W-1:0];
			end
		end
		return '0;
	endfunction

	// Apply one request to the shadow state and return the reply it earns.
	function automatic page_reply_t serve_request(logic fn,
			logic [pta_pkg::FIELD_W-1:0] proc, logic [pta_pkg::FIELD_W-1:0] count,
			logic [pta_pkg::FIELD_W-1:0] vpage);
		page_reply_t                r;
		logic [pta_pkg::PAGE_W-1:0] tbl;
		logic [pta_pkg::PAGE_W-1:0] data;
		r.status = pta_pkg::ST_OK;
		r.page   = '0;
		if (fn == pta_pkg::FUNC_ALLOC) begin
			if (int'(proc) < pta_pkg::PROCESSES) begin
				tbl = claim_lowest_free();
				if (tbl == '0) begin
					r.status = pta_pkg::ST_OOM_TABLE;
				end else begin
					table_of_process[proc] = tbl;
					r.page = tbl;
					// Data pages fill successive entries; pages taken before a
					// failure stay allocated and mapped.
					for (int i = 0; i < int'(count) && r.status == pta_pkg::ST_OK; i++) begin
						data = claim_lowest_free();
						if (data == '0)
							r.status = pta_pkg::ST_OOM_DATA;
						else
							mapped_page[{tbl, i[pta_pkg::ENTRY_W-1:0]}] = data;
					end
				end
			end
		end else if (int'(proc) < pta_pkg::PROCESSES) begin
			tbl = table_of_process[proc];
			if (tbl != '0)
				r.page = mapped_page[{tbl, vpage[pta_pkg::ENTRY_W-1:0]}];
		end
		r.map = '0;
		for (int i = 0; i < pta_pkg::MAP_W && i < pta_pkg::PAGES; i++)
			r.map[i] = used_map[i];
		return r;
	endfunction

	// Results are retired before the request of the same edge is predicted.
	always @(posedge clk or negedge arst_n) begin : track
		page_reply_t due;
		if (!arst_n) begin
			used_map = '0;
			used_map[0] = 1'b1;
			for (int i = 0; i < pta_pkg::PROCESSES; i++)
				table_of_process[i] = '0;
			for (int i = 0; i < pta_pkg::PT_DEPTH; i++)
				mapped_page[i] = '0;
			replies_due.delete();
			failures = 0;
			pending  = 0;
		end else begin
			if (done === 1'b1) begin
				if (replies_due.size() == 0) begin
					failures++;
					if (failures <= 10)
						$display("[%0t] unexpected result: status %0d page %0d map %h",
							$realtime, status, page, free_map);
				end else begin
					due = replies_due.pop_front();
					if (status !== due.status || page !== due.page || free_map !== due.map) begin
						failures++;
						if (failures <= 10)
							$display("[%0t] mismatch exp/got: status %0d/%0d page %0d/%0d map %h/%h",
								$realtime, due.status, status, due.page, page,
								due.map, free_map);
					end
				end
			end
			if (start && busy === 1'b0)
				replies_due.push_back(serve_request(func, process, data_pages, virtual_page));
			pending = replies_due.size();
		end
	end

endmodule

>>> tb/page_table_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_table_allocator_tb: top of the page table allocator testbench
// Drives a directed set of allocation and lookup requests, then a long random
// mix biased toward lookups of processes that own a table, with random idle
// bursts between requests. The checker beside the block predicts and compares
// every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module page_table_allocator_tb;

	localparam int ITEMS        = 1800;
	localparam int CALM_ITEMS   = 300;
	// Clearing pass plus slack for the slowest request.
	localparam int STALL_LIMIT  = 20000;
	localparam int DRAIN_CYCLES = 80;

	logic                          clk;
	logic                          arst_n       = 1'b0;
	logic                          start        = 1'b0;
	logic                          busy;
	logic                          func         = pta_pkg::FUNC_ALLOC;
	logic [pta_pkg::FIELD_W-1:0]   process      = '0;
	logic [pta_pkg::FIELD_W-1:0]   data_pages   = '0;
	logic [pta_pkg::FIELD_W-1:0]   virtual_page = '0;
	logic                          done;
	logic [1:0]                    status;
	logic [pta_pkg::FIELD_W-1:0]   page;
	logic [pta_pkg::MAP_W-1:0]     free_map;
	int                            failures;
	int                            pending;
	int                            quiet_cycles = 0;

	page_table_allocator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.func         (func),
		.process      (process),
		.data_pages   (data_pages),
		.virtual_page (virtual_page),
		.done         (done),
		.status       (status),
		.page         (page),
		.free_map     (free_map)
	);

	page_table_allocator_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.func         (func),
		.process      (process),
		.data_pages   (data_pages),
		.virtual_page (virtual_page),
		.done         (done),
		.status       (status),
		.page         (page),
		.free_map     (free_map),
		.failures     (failures),
		.pending      (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// End the run when nothing moves on either side for too long.
	always @(posedge clk) begin : watchdog
		if ((start && busy === 1'b0) || done === 1'b1) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Present one request and hold it until the block takes it; start stays
	// high so a following request can go out on the very next edge.
	task automatic issue(logic fn, logic [pta_pkg::FIELD_W-1:0] proc,
			logic [pta_pkg::FIELD_W-1:0] cnt, logic [pta_pkg::FIELD_W-1:0] vpg);
		func         <= fn;
		process      <= proc;
		data_pages   <= cnt;
		virtual_page <= vpg;
		start        <= 1'b1;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
	endtask

	task automatic pause(int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	initial begin : stimulus
		logic [pta_pkg::FIELD_W-1:0] proc;
		logic [pta_pkg::FIELD_W-1:0] cnt;
		logic [pta_pkg::FIELD_W-1:0] vpg;
		logic [pta_pkg::FIELD_W-1:0] owners [$];

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Lookups before any table exists answer page 0.
		issue(pta_pkg::FUNC_LOOKUP, 6'd0, 6'd0, 6'd0);
		issue(pta_pkg::FUNC_LOOKUP, 6'd63, 6'd63, 6'd63);
		// Zero data pages takes only the table page.
		issue(pta_pkg::FUNC_ALLOC, 6'd0, 6'd0, 6'd0);
		issue(pta_pkg::FUNC_LOOKUP, 6'd0, 6'd0, 6'd0);
		issue(pta_pkg::FUNC_ALLOC, 6'd63, 6'd3, 6'd0);
		issue(pta_pkg::FUNC_LOOKUP, 6'd63, 6'd0, 6'd0);
		issue(pta_pkg::FUNC_LOOKUP, 6'd63, 6'd0, 6'd2);
		issue(pta_pkg::FUNC_LOOKUP, 6'd63, 6'd0, 6'd3);
		issue(pta_pkg::FUNC_LOOKUP, 6'd63, 6'd0, 6'd63);
		// A second allocation replaces the pointer and leaks the old pages.
		issue(pta_pkg::FUNC_ALLOC, 6'd0, 6'd2, 6'd0);
		issue(pta_pkg::FUNC_LOOKUP, 6'd0, 6'd0, 6'd1);
		// Fields that the operation ignores carry all ones.
		issue(pta_pkg::FUNC_ALLOC, 6'd42, 6'd1, 6'd63);
		issue(pta_pkg::FUNC_LOOKUP, 6'd42, 6'd63, 6'd0);
		// Out of memory on a data page, then on the table page itself.
		issue(pta_pkg::FUNC_ALLOC, 6'd21, 6'd63, 6'd0);
		issue(pta_pkg::FUNC_LOOKUP, 6'd21, 6'd0, 6'd0);
		issue(pta_pkg::FUNC_LOOKUP, 6'd21, 6'd0, 6'd50);
		issue(pta_pkg::FUNC_ALLOC, 6'd22, 6'd5, 6'd0);
		issue(pta_pkg::FUNC_LOOKUP, 6'd22, 6'd0, 6'd0);
		issue(pta_pkg::FUNC_LOOKUP, 6'd42, 6'd0, 6'd0);
		owners = '{6'd0, 6'd63, 6'd42, 6'd21};

		// Random mix: mostly lookups into owned tables, some allocations.
		for (int n = 0; n < ITEMS; n++) begin
			if (n < ITEMS - CALM_ITEMS && $urandom_range(0, 3) == 0)
				pause($urandom_range(1, 9));
			if ($urandom_range(0, 9) < 3) begin
				proc = pta_pkg::FIELD_W'($urandom_range(0, 63));
				case ($urandom_range(0, 5))
					0, 1, 2: begin
						cnt = pta_pkg::FIELD_W'($urandom_range(0, 4));
					end
					3, 4: begin
						cnt = pta_pkg::FIELD_W'($urandom_range(5, 15));
					end
					default: begin
						cnt = pta_pkg::FIELD_W'($urandom_range(0, 63));
					end
				endcase
				vpg = pta_pkg::FIELD_W'($urandom_range(0, 63));
				issue(pta_pkg::FUNC_ALLOC, proc, cnt, vpg);
				owners.push_back(proc);
			end else begin
				if ($urandom_range(0, 3) != 0)
					proc = owners[$urandom_range(0, owners.size() - 1)];
				else
					proc = pta_pkg::FIELD_W'($urandom_range(0, 63));
				if ($urandom_range(0, 1) == 0)
					vpg = pta_pkg::FIELD_W'($urandom_range(0, 7));
				else
					vpg = pta_pkg::FIELD_W'($urandom_range(0, 63));
				cnt = pta_pkg::FIELD_W'($urandom_range(0, 63));
				issue(pta_pkg::FUNC_LOOKUP, proc, cnt, vpg);
			end
		end

		// Let every outstanding request come back, then a little longer.
		start <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (failures == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
